>>> src/srsw_pkg.sv
// srsw_pkg: request and result types, command and status codes
// shared by the sender window modules and its checker; no dependencies
`timescale 1ns / 1ps

package srsw_pkg;

    localparam logic [1:0] CMD_SEND    = 2'd0;
    localparam logic [1:0] CMD_ACK     = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_WIN_FULL    = 3'd1;
    localparam logic [2:0] ST_CORRUPT_ACK = 3'd2;
    localparam logic [2:0] ST_ACK_OUTSIDE = 3'd3;
    localparam logic [2:0] ST_TO_IGNORED  = 3'd4;

    localparam logic [3:0] RESET_WINDOW = 4'd5;
    localparam int unsigned START_SEQ   = 1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] payload;
        logic [15:0] ack_number;
        logic        ack_intact;
        logic [15:0] expired_seq;
    } srsw_in_t;

    typedef struct packed {
        logic        tx_valid;
        logic [15:0] tx_seq;
        logic [63:0] tx_payload;
        logic        timer_start;
        logic        timer_stop;
        logic [15:0] timer_seq;
        logic [3:0]  slide_count;
        logic        window_full;
        logic [2:0]  status;
    } srsw_out_t;

endpackage

>>> src/srsw_payload_ram.sv
// srsw_payload_ram: payload store, one write port and one registered read port
// no package dependencies
`timescale 1ns / 1ps

module srsw_payload_ram #(
    parameter int DEPTH  = 8,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = 3
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/srsw_window_ctrl.sv
// srsw_window_ctrl: window base, next number, outstanding count, ack marks,
// window size register and the per-request decision; uses srsw_pkg
`timescale 1ns / 1ps

module srsw_window_ctrl #(
    parameter int WINDOW_MAX   = 8,
    parameter int SEQ_BITS     = 16,
    parameter int PAYLOAD_BITS = 64,
    parameter int IDX_W        = 3,
    parameter int CNT_W        = 4
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [3:0]              cfg_data,
    input  logic                    accept,
    input  srsw_pkg::srsw_in_t      req,
    output srsw_pkg::srsw_out_t     res,
    output logic                    use_mem,
    output logic                    ram_we,
    output logic [IDX_W-1:0]        ram_waddr,
    output logic [PAYLOAD_BITS-1:0] ram_wdata,
    output logic                    ram_re,
    output logic [IDX_W-1:0]        ram_raddr
);

    import srsw_pkg::*;

    localparam int CW = (CNT_W > 4) ? CNT_W : 4;
    localparam int DW = (SEQ_BITS > CNT_W) ? SEQ_BITS : CNT_W;

    logic [3:0]            window_size_reg;
    logic [SEQ_BITS-1:0]   base_reg, base_next;
    logic [SEQ_BITS-1:0]   next_seq_reg, next_seq_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [WINDOW_MAX-1:0] acked_reg, acked_next;

    logic [CW-1:0]         eff_window;
    logic [SEQ_BITS-1:0]   ack_seq, exp_seq, ack_dist, exp_dist;
    logic [IDX_W-1:0]      ack_idx, exp_idx;
    logic                  ack_in_range, exp_in_range;
    logic [WINDOW_MAX-1:0] marks_new;
    logic [CNT_W-1:0]      run_len;
    logic                  run_on;
    logic [PAYLOAD_BITS-1:0] pay_in;

    function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
        if (s >= (CNT_W+1)'(WINDOW_MAX)) begin
            s = s - (CNT_W+1)'(WINDOW_MAX);
        end
        return IDX_W'(s);
    endfunction

    always_comb begin
        if (window_size_reg == 4'd0) begin
            eff_window = CW'(1);
        end else if (CW'(window_size_reg) > CW'(WINDOW_MAX)) begin
            eff_window = CW'(WINDOW_MAX);
        end else begin
            eff_window = CW'(window_size_reg);
        end
    end

    assign ack_seq      = SEQ_BITS'(req.ack_number);
    assign exp_seq      = SEQ_BITS'(req.expired_seq);
    assign ack_dist     = ack_seq - base_reg;
    assign exp_dist     = exp_seq - base_reg;
    assign ack_idx      = IDX_W'(ack_dist);
    assign exp_idx      = IDX_W'(exp_dist);
    assign ack_in_range = DW'(ack_dist) < DW'(count_reg);
    assign exp_in_range = DW'(exp_dist) < DW'(count_reg);
    assign marks_new    = acked_reg | (WINDOW_MAX'(1) << ack_idx);
    assign pay_in       = PAYLOAD_BITS'(req.payload);

    // leading acknowledged slots from the base
    always_comb begin
        run_len = '0;
        run_on  = 1'b1;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            if (run_on && marks_new[i]) begin
                run_len = run_len + CNT_W'(1);
            end else begin
                run_on = 1'b0;
            end
        end
    end

    always_comb begin
        res           = '0;
        use_mem       = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = wrap_idx(head_reg, count_reg);
        ram_wdata     = pay_in;
        ram_re        = 1'b0;
        ram_raddr     = wrap_idx(head_reg, CNT_W'(exp_idx));
        base_next     = base_reg;
        next_seq_next = next_seq_reg;
        count_next    = count_reg;
        head_next     = head_reg;
        acked_next    = acked_reg;
        unique case (req.cmd)
            CMD_SEND: begin
                if (CW'(count_reg) >= eff_window) begin
                    res.status = ST_WIN_FULL;
                end else begin
                    ram_we          = accept;
                    count_next      = count_reg + CNT_W'(1);
                    next_seq_next   = next_seq_reg + SEQ_BITS'(1);
                    res.tx_valid    = 1'b1;
                    res.tx_seq      = 16'(next_seq_reg);
                    res.tx_payload  = 64'(pay_in);
                    res.timer_start = 1'b1;
                    res.timer_seq   = 16'(next_seq_reg);
                end
            end
            CMD_ACK: begin
                if (!req.ack_intact) begin
                    res.status = ST_CORRUPT_ACK;
                end else if (!ack_in_range) begin
                    res.status = ST_ACK_OUTSIDE;
                end else begin
                    if (!acked_reg[ack_idx]) begin
                        res.timer_stop = 1'b1;
                        res.timer_seq  = 16'(ack_seq);
                    end
                    acked_next      = marks_new >> run_len;
                    count_next      = count_reg - run_len;
                    base_next       = base_reg + SEQ_BITS'(run_len);
                    head_next       = wrap_idx(head_reg, run_len);
                    res.slide_count = 4'(run_len);
                end
            end
            CMD_TIMEOUT: begin
                if (!exp_in_range) begin
                    res.status = ST_TO_IGNORED;
                end else if (acked_reg[exp_idx]) begin
                    res.status = ST_TO_IGNORED;
                end else begin
                    ram_re          = accept;
                    use_mem         = 1'b1;
                    res.tx_valid    = 1'b1;
                    res.tx_seq      = 16'(exp_seq);
                    res.timer_start = 1'b1;
                    res.timer_seq   = 16'(exp_seq);
                end
            end
            default: begin
            end
        endcase
        res.window_full = CW'(count_next) >= eff_window;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= RESET_WINDOW;
            base_reg        <= SEQ_BITS'(START_SEQ);
            next_seq_reg    <= SEQ_BITS'(START_SEQ);
            count_reg       <= '0;
            head_reg        <= '0;
            acked_reg       <= '0;
        end else begin
            if (cfg_we) begin
                window_size_reg <= cfg_data;
            end
            if (accept) begin
                base_reg     <= base_next;
                next_seq_reg <= next_seq_next;
                count_reg    <= count_next;
                head_reg     <= head_next;
                acked_reg    <= acked_next;
            end
        end
    end

endmodule

>>> src/selective_repeat_sender_window.sv
// Selective-repeat sender window. One request is taken per cycle and its result
// is registered, appearing the cycle after acceptance; a new request is taken
// whenever the result register is empty or being drained. Send payloads go into
// a WINDOW_MAX-entry payload RAM addressed from a circular head pointer, and a
// retransmission reads its payload through the RAM's registered read port, which
// lands together with the result. The ack slide is a trailing-ones count over the
// WINDOW_MAX acknowledge marks, done in the cycle the ack is accepted. The
// window size register is written through cfg_valid/cfg_ready (always ready)
// and must only change while no request is in flight. No clearing pass after reset.
// Depends on srsw_pkg, srsw_window_ctrl and srsw_payload_ram.
`timescale 1ns / 1ps

module selective_repeat_sender_window #(
    parameter int WINDOW_MAX   = 8,
    parameter int SEQ_BITS     = 16,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  srsw_pkg::srsw_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output srsw_pkg::srsw_out_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [3:0]          cfg_data
);

    import srsw_pkg::*;

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    logic                    accept;
    srsw_out_t               res;
    logic                    use_mem;
    logic                    ram_we, ram_re;
    logic [IDX_W-1:0]        ram_waddr, ram_raddr;
    logic [PAYLOAD_BITS-1:0] ram_wdata, ram_rdata;

    logic      out_valid_reg;
    srsw_out_t out_reg;
    logic      use_mem_reg;

    assign cfg_ready = 1'b1;
    assign s_ready   = !out_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    srsw_window_ctrl #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SEQ_BITS     (SEQ_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .req       (s_data),
        .res       (res),
        .use_mem   (use_mem),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr)
    );

    srsw_payload_ram #(
        .DEPTH  (WINDOW_MAX),
        .WIDTH  (PAYLOAD_BITS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg     <= res;
            use_mem_reg <= use_mem;
        end
    end

    always_comb begin
        m_data = out_reg;
        if (use_mem_reg) begin
            m_data.tx_payload = 64'(ram_rdata);
        end
    end

    assign m_valid = out_valid_reg;

endmodule

>>> src/srsw_checker.sv
// srsw_checker: port-level assertions on the sender window, bound to the top level
// uses srsw_pkg
`timescale 1ns / 1ps

module srsw_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input srsw_pkg::srsw_out_t m_data
);

    import srsw_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // every accepted request yields a result next cycle
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted request gave no result");

    // a refused send transmits nothing and reports full
    a_refused: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_WIN_FULL |-> !m_data.tx_valid && m_data.window_full)
        else $error("refused send inconsistent");

    // timer start goes with a transmission and never with a stop
    a_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.timer_start |-> m_data.tx_valid && !m_data.timer_stop
            && m_data.timer_seq == m_data.tx_seq)
        else $error("timer start without matching transmission");

    // only a good ack slides the window
    a_slide: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.slide_count != 4'd0 |-> m_data.status == ST_OK && !m_data.tx_valid)
        else $error("slide on a request that is not a good ack");

endmodule

bind selective_repeat_sender_window srsw_checker u_srsw_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
